>>> hw/rtl/pru_pkg.sv
// ---------------------------------------------------------------------------
// PNG row unfilter package
// Filter type codes and limits shared by the row unfilter modules.
// ---------------------------------------------------------------------------
package pru_pkg;

	typedef enum logic [2:0] {
		FLT_NONE  = 3'd0,
		FLT_SUB   = 3'd1,
		FLT_UP    = 3'd2,
		FLT_AVG   = 3'd3,
		FLT_PAETH = 3'd4
	} filter_t;

	// Highest valid filter type carried in a filter byte.
	localparam logic [7:0] FILTER_MAX = 8'd4;

endpackage

>>> hw/rtl/pru_ram.sv
// ---------------------------------------------------------------------------
// PNG row unfilter RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module pru_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16384,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/pru_predict.sv
// ---------------------------------------------------------------------------
// PNG row unfilter predictor
// Forms the prediction for one sample from its left, upper and upper-left
// neighbours according to the filter type of the row.
// ---------------------------------------------------------------------------
module pru_predict
	import pru_pkg::*;
(
	input  filter_t    filter,
	input  logic [7:0] left,
	input  logic [7:0] up,
	input  logic [7:0] up_left,
	output logic [7:0] pred
);

	logic signed [10:0] da_diff;
	logic signed [10:0] db_diff;
	logic signed [10:0] dc_diff;
	logic [9:0]         da;
	logic [9:0]         db;
	logic [9:0]         dc;
	logic [8:0]         avg_sum;
	logic [7:0]         paeth;

	// Distances from the estimate a + b - c to a, b and c.
	always_comb begin
		da_diff = $signed({3'b000, up}) - $signed({3'b000, up_left});
		db_diff = $signed({3'b000, left}) - $signed({3'b000, up_left});
		dc_diff = $signed({3'b000, left}) + $signed({3'b000, up})
			- $signed({2'b00, up_left, 1'b0});
		da = da_diff[10] ? 10'(-da_diff) : da_diff[9:0];
		db = db_diff[10] ? 10'(-db_diff) : db_diff[9:0];
		dc = dc_diff[10] ? 10'(-dc_diff) : dc_diff[9:0];
		if (da <= db && da <= dc) begin
			paeth = left;
		end else if (db <= dc) begin
			paeth = up;
		end else begin
			paeth = up_left;
		end
		avg_sum = {1'b0, left} + {1'b0, up};
	end

	always_comb begin
		case (filter)
			FLT_SUB:   pred = left;
			FLT_UP:    pred = up;
			FLT_AVG:   pred = avg_sum[8:1];
			FLT_PAETH: pred = paeth;
			default:   pred = 8'd0;
		endcase
	end

endmodule

>>> hw/rtl/png_row_unfilter.sv
// ---------------------------------------------------------------------------
// PNG row unfilter
// Rebuilds PNG scanline samples from the inflated byte stream with the
// None, Sub, Up, Average and Paeth filters, keeping the row above in a RAM.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid, in_ready   | data_byte, image_start
//  out     | output    | out_valid, out_ready | sample, row_last, bad_filter
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One byte is accepted per cycle unless output stalls; samples pass stage s1 and the output register.
// The line store read issued at acceptance sets the stage boundary.
// Reset clears all control state at once; no clearing pass is needed.
// A stalled output holds the pipeline stage, and the input waits with it.
// ---------------------------------------------------------------------------
module png_row_unfilter
	import pru_pkg::*;
#(
	parameter int unsigned MAX_ROW_BYTES   = 16384,
	parameter int unsigned MAX_PIXEL_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        image_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  sample,
	output logic        row_last,
	output logic        bad_filter,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data
);

	localparam int unsigned AW = $clog2(MAX_ROW_BYTES);
	localparam int unsigned LW = $clog2(MAX_ROW_BYTES + 1);
	localparam int unsigned EW = (LW > 15) ? LW : 15;
	localparam int unsigned PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	localparam logic CFG_BPP     = 1'b0;
	localparam logic CFG_ROW_LEN = 1'b1;

	// Configuration registers.
	logic [3:0]  bpp_q;
	logic [14:0] row_len_q;

	// Row control state.
	logic [AW-1:0] col_q;
	logic          exp_q;
	logic          first_q;
	logic          err_q;
	filter_t       filt_q;

	logic [7:0] left_q    [MAX_PIXEL_BYTES];
	logic [7:0] up_left_q [MAX_PIXEL_BYTES];

	// Reconstruction stage.
	logic          s1_valid_s1;
	logic          s1_err_s1;
	logic          s1_first_s1;
	logic          s1_last_s1;
	logic [7:0]    s1_byte_s1;
	logic [AW-1:0] s1_col_s1;
	filter_t       s1_filt_s1;

	// Output register.
	logic       out_valid_q;
	logic [7:0] sample_q;
	logic       row_last_q;
	logic       bad_q;

	logic          in_acc;
	logic          s1_adv;
	logic [EW-1:0] len_eff;
	logic [EW-1:0] col_inc;
	logic [3:0]    bpp_eff;
	logic [PW-1:0] bpp_idx;
	logic          err_d;
	logic          exp_d;
	logic          first_d;
	logic [AW-1:0] col_d;
	filter_t       filt_d;
	logic          load_s1;
	logic          load_err;
	logic          load_last;
	logic          clr_nb;
	logic          ram_re;
	logic          ram_we;
	logic [7:0]    ram_rdata;
	logic [7:0]    nb_a;
	logic [7:0]    nb_b;
	logic [7:0]    nb_c;
	logic [7:0]    pred;
	logic [7:0]    rec;

	assign s1_adv   = s1_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_s1 || s1_adv;
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		if (row_len_q == 15'd0) begin
			len_eff = EW'(1);
		end else if (EW'(row_len_q) > EW'(MAX_ROW_BYTES)) begin
			len_eff = EW'(MAX_ROW_BYTES);
		end else begin
			len_eff = EW'(row_len_q);
		end
		if (bpp_q == 4'd0) begin
			bpp_eff = 4'd1;
		end else if (bpp_q > 4'(MAX_PIXEL_BYTES)) begin
			bpp_eff = 4'(MAX_PIXEL_BYTES);
		end else begin
			bpp_eff = bpp_q;
		end
		bpp_idx = PW'(bpp_eff - 4'd1);
	end

	// Decisions taken on each request as it is accepted.
	always_comb begin
		err_d     = image_start ? 1'b0 : err_q;
		exp_d     = image_start || exp_q;
		first_d   = image_start || first_q;
		col_d     = image_start ? '0 : col_q;
		filt_d    = filt_q;
		col_inc   = EW'(col_d) + EW'(1);
		load_s1   = 1'b0;
		load_err  = 1'b0;
		load_last = 1'b0;
		clr_nb    = image_start;
		if (!err_d) begin
			if (exp_d) begin
				clr_nb = 1'b1;
				if (data_byte > FILTER_MAX) begin
					err_d    = 1'b1;
					load_s1  = 1'b1;
					load_err = 1'b1;
				end else begin
					filt_d = filter_t'(data_byte[2:0]);
					exp_d  = 1'b0;
					col_d  = '0;
				end
			end else begin
				load_s1   = 1'b1;
				load_last = col_inc >= len_eff;
				if (load_last) begin
					col_d   = '0;
					exp_d   = 1'b1;
					first_d = 1'b0;
				end else begin
					col_d = col_inc[AW-1:0];
				end
			end
		end
	end

	assign ram_re = in_acc && load_s1 && !load_err;
	assign ram_we = s1_adv && !s1_err_s1;

	pru_ram #(
		.WIDTH (8),
		.DEPTH (MAX_ROW_BYTES)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (s1_col_s1),
		.wdata (rec),
		.re    (ram_re),
		.raddr (col_q & {AW{!image_start}}),
		.rdata (ram_rdata)
	);

	assign nb_a = left_q[bpp_idx];
	assign nb_c = up_left_q[bpp_idx];
	assign nb_b = s1_first_s1 ? 8'd0 : ram_rdata;

	pru_predict u_predict (
		.filter  (s1_filt_s1),
		.left    (nb_a),
		.up      (nb_b),
		.up_left (nb_c),
		.pred    (pred)
	);

	assign rec = s1_byte_s1 + pred;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q     <= 4'd4;
			row_len_q <= 15'd4096;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BPP:     bpp_q     <= cfg_data[3:0];
				CFG_ROW_LEN: row_len_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			exp_q   <= 1'b1;
			first_q <= 1'b1;
			err_q   <= 1'b0;
			filt_q  <= FLT_NONE;
		end else if (in_acc) begin
			col_q   <= col_d;
			exp_q   <= exp_d;
			first_q <= first_d;
			err_q   <= err_d;
			filt_q  <= filt_d;
		end
	end

	// Neighbour history: a row start wipes it, and the wipe wins over a sample shifting in at the same time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(MAX_PIXEL_BYTES); i++) begin
				left_q[i]    <= 8'd0;
				up_left_q[i] <= 8'd0;
			end
		end else if (in_acc && clr_nb) begin
			for (int i = 0; i < int'(MAX_PIXEL_BYTES); i++) begin
				left_q[i]    <= 8'd0;
				up_left_q[i] <= 8'd0;
			end
		end else if (ram_we) begin
			left_q[0]    <= rec;
			up_left_q[0] <= nb_b;
			for (int i = 1; i < int'(MAX_PIXEL_BYTES); i++) begin
				left_q[i]    <= left_q[i-1];
				up_left_q[i] <= up_left_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_acc && load_s1) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && load_s1) begin
			s1_err_s1   <= load_err;
			s1_first_s1 <= first_d || image_start || first_q;
			s1_last_s1  <= load_last;
			s1_byte_s1  <= data_byte;
			s1_col_s1   <= image_start ? '0 : col_q;
			s1_filt_s1  <= filt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			sample_q   <= s1_err_s1 ? 8'd0 : rec;
			row_last_q <= !s1_err_s1 && s1_last_s1;
			bad_q      <= s1_err_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample     = sample_q;
	assign row_last   = row_last_q;
	assign bad_filter = bad_q;

`ifndef ASSERT_OFF
	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (s1_col_s1 != (col_q & {AW{!image_start}})))
		else $error("Line store read and write hit the same entry.");

	a_err_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && err_q && !image_start) |-> !load_s1)
		else $error("A dropped request produced a result.");

	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_filter) |-> (sample == 8'd0 && !row_last))
		else $error("Error result carries sample data.");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !s1_adv) |=> (s1_valid_s1 && $stable(s1_byte_s1)
			&& $stable(nb_b)))
		else $error("Stalled stage lost its contents.");
`endif

endmodule
